@@ hw/rtl/signed_decimal_digit_emitter_unit_macros.svh @@
// Assertion macros for the signed decimal digit emitter.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SIGNED_DECIMAL_DIGIT_EMITTER_UNIT_MACROS_SVH
`define SIGNED_DECIMAL_DIGIT_EMITTER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define SDDE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SDDE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define SDDE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SDDE_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/sdde_pkg.sv @@
// Shared widths and character constants for the signed decimal digit emitter.
// Depends on nothing; used by the channel interfaces and the top level.
package sdde_pkg;

	localparam int ROW_W    = 8;
	localparam int COL_W    = 8;
	localparam int NUM_W    = 16;
	localparam int MIND_W   = 8;
	localparam int CODE_W   = 7;
	localparam int PITCH_W  = 4;
	localparam int MAG_W    = NUM_W + 1;

	localparam logic [PITCH_W-1:0] PITCH_RESET = 4'd6;
	localparam logic [COL_W-1:0]   COL_ORIGIN  = 8'd2;
	localparam logic [CODE_W-1:0]  ASCII_ZERO  = 7'h30;
	localparam logic [CODE_W-1:0]  ASCII_NINE  = 7'h39;
	localparam logic [CODE_W-1:0]  ASCII_MINUS = 7'h2D;

endpackage

@@ hw/rtl/sdde_if.sv @@
// Valid/ready channel interfaces: numbers in, characters out.
// Depends on sdde_pkg for the field widths.
interface sdde_in_if;
	logic                              valid;
	logic                              ready;
	logic [sdde_pkg::ROW_W-1:0]        text_row;
	logic [sdde_pkg::COL_W-1:0]        start_column;
	logic signed [sdde_pkg::NUM_W-1:0] number;
	logic [sdde_pkg::MIND_W-1:0]       min_digits;

	modport source (output valid, output text_row, output start_column,
		output number, output min_digits, input ready);
	modport sink (input valid, input text_row, input start_column,
		input number, input min_digits, output ready);
endinterface

interface sdde_out_if;
	logic                        valid;
	logic                        ready;
	logic [sdde_pkg::ROW_W-1:0]  out_row;
	logic [sdde_pkg::COL_W-1:0]  pixel_column;
	logic [sdde_pkg::CODE_W-1:0] char_code;
	logic                        last_char;

	modport source (output valid, output out_row, output pixel_column,
		output char_code, output last_char, input ready);
	modport sink (input valid, input out_row, input pixel_column,
		input char_code, input last_char, output ready);
endinterface

@@ hw/rtl/signed_decimal_digit_emitter_unit.sv @@
// Signed decimal digit emitter: turns a 16-bit value into a run of ASCII beats.
// Depends on sdde_pkg, sdde_if.sv and signed_decimal_digit_emitter_unit_macros.svh.
// A number passes the input register, the worker and the output register in that order.
// Throughput: one slot per cycle (sign, five places), held while a slot's character waits on
// a full output register; a blanked place or no sign still uses its slot.
// Reset: arst_n clears the control state asynchronously; pitch_q returns to 6.
`include "signed_decimal_digit_emitter_unit_macros.svh"

module signed_decimal_digit_emitter_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sdde_pkg::PITCH_W-1:0]    cfg_wdata,
	sdde_in_if.sink                         value,
	sdde_out_if.source                      chars
);

	// Work slots, one per cycle unless stalled: sign, then ten-thousands down to units.
	typedef enum logic [2:0] {
		SLOT_SIGN,
		SLOT_10K,
		SLOT_1K,
		SLOT_100,
		SLOT_10,
		SLOT_UNIT
	} slot_t;

	localparam int DIG_W = 4;

	// Pitch register.
	logic [sdde_pkg::PITCH_W-1:0] pitch_q;

	// Input register: holds one number beat ahead of the worker.
	logic                              valid_s1;
	logic [sdde_pkg::ROW_W-1:0]        row_s1;
	logic [sdde_pkg::COL_W-1:0]        scol_s1;
	logic [sdde_pkg::NUM_W-1:0]        number_s1;
	logic [sdde_pkg::MIND_W-1:0]       mind_s1;

	// Worker: walks the slots of the number it holds.
	logic                              busy_q;
	slot_t                             slot_q;
	logic [sdde_pkg::ROW_W-1:0]        row_q;
	logic [sdde_pkg::COL_W-1:0]        col_q;
	logic [sdde_pkg::MAG_W-1:0]        rem_q;
	logic                              neg_q;
	logic [sdde_pkg::MIND_W-1:0]       mind_q;
	logic                              blank_q;

	// Output register.
	logic                              out_valid_q;
	logic [sdde_pkg::ROW_W-1:0]        out_row_q;
	logic [sdde_pkg::COL_W-1:0]        out_col_q;
	logic [sdde_pkg::CODE_W-1:0]       out_code_q;
	logic                              out_last_q;

	logic                              accept;
	logic                              load;
	logic                              out_free;
	logic                              step_en;
	logic                              done;
	logic                              emit;
	logic                              place_slot;
	logic                              forced;
	logic [sdde_pkg::CODE_W-1:0]       emit_code;
	logic                              emit_last;
	logic [sdde_pkg::MAG_W-1:0]        weight;
	logic [8:0]                        ge;
	logic [DIG_W-1:0]                  digit;
	logic [sdde_pkg::MAG_W-1:0]        rem_next;
	logic [sdde_pkg::COL_W-1:0]        load_col;
	logic [sdde_pkg::MAG_W-1:0]        load_mag;
	logic [sdde_pkg::COL_W+sdde_pkg::PITCH_W-1:0] scaled_col;

	// Input side: the register parts the two handshakes.
	assign value.ready = !valid_s1;
	assign accept      = value.valid && value.ready;

	// Pitch register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= sdde_pkg::PITCH_RESET;
		end else if (cfg_we) begin
			pitch_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1    <= value.text_row;
			scol_s1   <= value.start_column;
			number_s1 <= value.number;
			mind_s1   <= value.min_digits;
		end
	end

	// Start column and magnitude of the held number. -32768 yields 32768.
	assign scaled_col = {{sdde_pkg::PITCH_W{1'b0}}, scol_s1}
		* {{sdde_pkg::COL_W{1'b0}}, pitch_q};
	assign load_col   = scaled_col[sdde_pkg::COL_W-1:0] + sdde_pkg::COL_ORIGIN;
	assign load_mag   = number_s1[sdde_pkg::NUM_W-1]
		? sdde_pkg::MAG_W'((1 << sdde_pkg::NUM_W) - {1'b0, number_s1})
		: {1'b0, number_s1};

	// Place weight and the min_digits code that forces this place shown.
	always_comb begin
		weight     = '0;
		forced     = 1'b0;
		place_slot = 1'b0;
		case (slot_q)
			SLOT_10K: begin
				weight     = sdde_pkg::MAG_W'(10000);
				forced     = (mind_q == 8'd5);
				place_slot = 1'b1;
			end
			SLOT_1K: begin
				weight     = sdde_pkg::MAG_W'(1000);
				forced     = (mind_q == 8'd4);
				place_slot = 1'b1;
			end
			SLOT_100: begin
				weight     = sdde_pkg::MAG_W'(100);
				forced     = (mind_q == 8'd3);
				place_slot = 1'b1;
			end
			SLOT_10: begin
				weight     = sdde_pkg::MAG_W'(10);
				forced     = (mind_q == 8'd2);
				place_slot = 1'b1;
			end
			default: begin
				weight     = '0;
				forced     = 1'b0;
				place_slot = 1'b0;
			end
		endcase
	end

	// Digit by nine parallel compares against k * weight; the remainder stays
	// below ten times the weight, so the count of passed thresholds is the digit.
	always_comb begin
		for (int k = 1; k <= 9; k++) begin
			ge[k-1] = (rem_q >= sdde_pkg::MAG_W'(k * weight));
		end
	end

	assign digit    = DIG_W'($countones(ge));
	assign rem_next = rem_q - sdde_pkg::MAG_W'(digit * weight);

	// What the current slot puts out, if anything.
	always_comb begin
		emit      = 1'b0;
		emit_code = sdde_pkg::ASCII_ZERO;
		emit_last = 1'b0;
		case (slot_q) inside
			SLOT_SIGN: begin
				emit      = neg_q;
				emit_code = sdde_pkg::ASCII_MINUS;
			end
			SLOT_10K, SLOT_1K, SLOT_100, SLOT_10: begin
				// Drop the digit while still blanking a leading zero.
				emit      = !blank_q || (digit != '0) || forced;
				emit_code = sdde_pkg::ASCII_ZERO + sdde_pkg::CODE_W'(digit);
			end
			SLOT_UNIT: begin
				emit      = 1'b1;
				emit_code = sdde_pkg::ASCII_ZERO + sdde_pkg::CODE_W'(rem_q[DIG_W-1:0]);
				emit_last = 1'b1;
			end
			default: begin
				emit      = 1'b0;
				emit_code = sdde_pkg::ASCII_ZERO;
				emit_last = 1'b0;
			end
		endcase
	end

	// Advance a slot unless it has a character and the output register is full.
	assign out_free = !out_valid_q || chars.ready;
	assign step_en  = busy_q && (!emit || out_free);
	assign done     = step_en && (slot_q == SLOT_UNIT);
	assign load     = valid_s1 && (!busy_q || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			slot_q  <= SLOT_SIGN;
			row_q   <= '0;
			col_q   <= '0;
			rem_q   <= '0;
			neg_q   <= 1'b0;
			mind_q  <= '0;
			blank_q <= 1'b1;
		end else if (load) begin
			busy_q  <= 1'b1;
			slot_q  <= SLOT_SIGN;
			row_q   <= row_s1;
			col_q   <= load_col;
			rem_q   <= load_mag;
			neg_q   <= number_s1[sdde_pkg::NUM_W-1];
			mind_q  <= mind_s1;
			blank_q <= 1'b1;
		end else if (step_en) begin
			if (done) begin
				busy_q <= 1'b0;
			end else begin
				slot_q <= slot_t'(slot_q + 3'd1);
			end
			if (emit) begin
				col_q <= col_q + sdde_pkg::COL_W'(pitch_q);
			end
			if (place_slot) begin
				rem_q <= rem_next;
				if (emit) begin
					blank_q <= 1'b0;
				end
			end
		end
	end

	// Output register: hold while stalled, refill as soon as it drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step_en && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step_en && emit) begin
			out_row_q  <= row_q;
			out_col_q  <= col_q;
			out_code_q <= emit_code;
			out_last_q <= emit_last;
		end
	end

	assign chars.valid        = out_valid_q;
	assign chars.out_row      = out_row_q;
	assign chars.pixel_column = out_col_q;
	assign chars.char_code    = out_code_q;
	assign chars.last_char    = out_last_q;

	// The remainder fits below ten of the place weight at the thousands and units places.
	`SDDE_ASSERT_IMP(a_rem_1k, clk, arst_n, busy_q && (slot_q == SLOT_1K), rem_q < 17'd10000)
	`SDDE_ASSERT_IMP(a_rem_unit, clk, arst_n, busy_q && (slot_q == SLOT_UNIT), rem_q < 17'd10)
	// The worker goes idle after the units slot unless a number is waiting.
	`SDDE_ASSERT_NXT(a_done_idle, clk, arst_n, done && !load, !busy_q)
	// A final beat carries a digit, never the minus sign.
	`SDDE_ASSERT_IMP(a_last_digit, clk, arst_n, out_valid_q && out_last_q,
		(out_code_q >= sdde_pkg::ASCII_ZERO) && (out_code_q <= sdde_pkg::ASCII_NINE))
	// A load always leaves the worker busy in its sign slot.
	`SDDE_ASSERT_NXT(a_load_start, clk, arst_n, load, busy_q && (slot_q == SLOT_SIGN))

endmodule
